/* rtl/ipl_pkg.sv */
// Shared types and constants for the inode group placement block.
// Holds item, result and table entry structs, state and pass codes.
// No dependencies.
package ipl_pkg;

  localparam int MAX_GROUPS = 64;
  localparam int COUNT_BITS = 16;
  localparam int GROUP_BITS = 6;
  localparam int NG_BITS    = 7;
  localparam int SUM_BITS   = 22;
  localparam int CFG_BITS   = 3;
  localparam int DVD_BITS   = 33;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_DIR     = 2'd1;
  localparam logic [1:0] MODE_FILE    = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOFIT = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam logic [CFG_BITS-1:0] CFG_NUM_GROUPS  = 3'd0;
  localparam logic [CFG_BITS-1:0] CFG_INODES_PG   = 3'd1;
  localparam logic [CFG_BITS-1:0] CFG_BLOCKS_PG   = 3'd2;
  localparam logic [CFG_BITS-1:0] CFG_TOTAL_BLKS  = 3'd3;
  localparam logic [CFG_BITS-1:0] CFG_OLD_POLICY  = 3'd4;

  localparam logic [2:0] DIV_AVG_I = 3'd0;
  localparam logic [2:0] DIV_AVG_B = 3'd1;
  localparam logic [2:0] DIV_AVG_D = 3'd2;
  localparam logic [2:0] DIV_SEED  = 3'd3;
  localparam logic [2:0] DIV_PG    = 3'd4;
  localparam logic [2:0] DIV_HASH  = 3'd5;

  typedef struct packed {
    logic [1:0]            mode;
    logic [GROUP_BITS-1:0] parent_group;
    logic [31:0]           parent_inode;
    logic                  parent_is_top;
    logic [31:0]           start_seed;
    logic [15:0]           entry_free_inodes;
    logic [15:0]           entry_free_blocks;
    logic [15:0]           entry_dirs;
    logic                  released_is_dir;
  } item_t;

  typedef struct packed {
    logic [GROUP_BITS-1:0] chosen_group;
    logic [1:0]            status;
    logic [SUM_BITS-1:0]   total_free_inodes;
    logic [SUM_BITS-1:0]   total_dirs;
  } result_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] fi;
    logic [COUNT_BITS-1:0] fb;
    logic [COUNT_BITS-1:0] dc;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SETUP, ST_SCAN_RD, ST_SCAN_EV, ST_UPD_RD, ST_UPD_WR
  } state_e;

  typedef enum logic [2:0] {
    P_OLD, P_TOP, P_NEAR, P_FBA, P_FBB, P_FPAR, P_FPROBE, P_FLIN
  } pass_e;

endpackage

/* rtl/inode_group_placement.sv */
// Inode group placement: per-group count table, placement scans and release.
// Depends on ipl_pkg and ipl_ram.
//
// Usage:
//   Items enter on item_i when start is high and busy is low. Each item gives
//   one result on result_o, marked by done_o for exactly one cycle; the
//   receiver cannot stall, so results are never held. Configuration is
//   written through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle
//   (the user's duty: not enforced); indexes 3 and 5 to 7 are ignored.
// Sequence:
//   Load and release: the entry is read (ST_UPD_RD), then written (ST_UPD_WR)
//   and the result registered onto done_o / result_o; a release of a group
//   outside the active range skips the read and writes nothing.
//   Placement: 6 serial divisions (averages and modulo starts, one shared
//   quotient bit per cycle), a setup step, then a read and an evaluate state
//   per group entry visited through the single table port, then the update
//   read and write (only the write when no group fits). Directory placement
//   visits up to 3n entries, file placement up to n + ceil(log2(n)) + 1.
//   One item is in work at a time.
// Reset:
//   Clears the sums, all table entries (per-entry valid bits) and sets the
//   registers to their defaults; the block is idle at once.
module inode_group_placement (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  ipl_pkg::item_t           item_i,
  output logic                     done_o,
  output ipl_pkg::result_t         result_o,
  input  logic                     cfg_we_i,
  input  logic [ipl_pkg::CFG_BITS-1:0] cfg_idx_i,
  input  logic [31:0]              cfg_data_i
);
  import ipl_pkg::*;

  state_e state_q, state_d;
  pass_e  pass_q, pass_d;
  item_t  item_q, item_d;

  logic [NG_BITS-1:0]    ngrp_q, n_w;
  logic [15:0]           ipg_q, bpg_q;
  logic                  oldpol_q;

  logic [SUM_BITS-1:0]   sum_fi_q, sum_fi_d, sum_fb_q, sum_fb_d, sum_d_q, sum_d_d;
  logic [MAX_GROUPS-1:0] valid_q, valid_d;

  logic [SUM_BITS-1:0]   avg_i_q, avg_i_d, avg_b_q, avg_b_d, avg_d_q, avg_d_d;
  logic [GROUP_BITS-1:0] seed_mod_q, seed_mod_d, pg_mod_q, pg_mod_d;
  logic [GROUP_BITS-1:0] hash_mod_q, hash_mod_d;

  logic [2:0]            div_op_q, div_op_d;
  logic [5:0]            div_bit_q, div_bit_d;
  logic [NG_BITS-1:0]    div_rem_q, div_rem_d;
  logic [DVD_BITS-1:0]   div_dvd_q, div_dvd_d;
  logic [SUM_BITS-1:0]   div_quo_q, div_quo_d;
  logic [NG_BITS:0]      rem_ext;
  logic                  rem_ge;
  logic [NG_BITS-1:0]    rem_new;
  logic [SUM_BITS-1:0]   quo_new;

  logic [GROUP_BITS-1:0] g_q, g_d, start_q, start_d, best_q, best_d, tgt_q, tgt_d;
  logic [NG_BITS-1:0]    cnt_q, cnt_d, step_q, step_d, step_n;
  logic                  found_q, found_d, fail_q, fail_d;
  logic [COUNT_BITS-1:0] best_fb_q, best_fb_d, maxc_q, maxc_d;

  logic                  done_q, done_d;
  result_t               res_q, res_d;

  logic                  ram_we, rd_valid_q;
  logic [GROUP_BITS-1:0] ram_addr;
  entry_t                ram_wdata, ram_rdata, ent;

  logic                  fi_nz, c_avg_i, c_old, c_top, c_near, c_file, last;
  logic [SUM_BITS:0]     dir_cap;
  logic [GROUP_BITS-1:0] lin_g, probe_g, adv_g, probe_next_g;

  function automatic logic [GROUP_BITS-1:0] wrap_add(logic [GROUP_BITS-1:0] g,
                                                     logic [NG_BITS-1:0] inc,
                                                     logic [NG_BITS-1:0] n);
    logic [NG_BITS:0] s;
    s = {2'b00, g} + {1'b0, inc};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[GROUP_BITS-1:0];
  endfunction

  function automatic logic [DVD_BITS-1:0] dividend(logic [2:0] op, item_t it,
                                                   logic [SUM_BITS-1:0] s_fi,
                                                   logic [SUM_BITS-1:0] s_fb,
                                                   logic [SUM_BITS-1:0] s_d);
    logic [DVD_BITS-1:0] v;
    case (op)
      DIV_AVG_I: v = {{(DVD_BITS-SUM_BITS){1'b0}}, s_fi};
      DIV_AVG_B: v = {{(DVD_BITS-SUM_BITS){1'b0}}, s_fb};
      DIV_AVG_D: v = {{(DVD_BITS-SUM_BITS){1'b0}}, s_d};
      DIV_SEED:  v = {1'b0, it.start_seed};
      DIV_PG:    v = {{(DVD_BITS-GROUP_BITS){1'b0}}, it.parent_group};
      DIV_HASH:  v = {1'b0, it.parent_inode}
                     + {{(DVD_BITS-GROUP_BITS){1'b0}}, it.parent_group};
      default:   v = '0;
    endcase
    return v;
  endfunction

  assign n_w  = (ngrp_q == '0) ? NG_BITS'(1) :
                (ngrp_q > NG_BITS'(MAX_GROUPS)) ? NG_BITS'(MAX_GROUPS) : ngrp_q;
  assign busy = (state_q != ST_IDLE);

  assign ram_addr = (state_q == ST_UPD_RD || state_q == ST_UPD_WR) ? tgt_q : g_q;
  assign ent      = rd_valid_q ? ram_rdata : '0;

  ipl_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_GROUPS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign rem_ext = {div_rem_q, div_dvd_q[DVD_BITS-1]};
  assign rem_ge  = (rem_ext >= {1'b0, n_w});
  assign rem_new = rem_ge ? NG_BITS'(rem_ext - {1'b0, n_w}) : rem_ext[NG_BITS-1:0];
  assign quo_new = {div_quo_q[SUM_BITS-2:0], rem_ge};

  assign fi_nz    = (ent.fi != '0);
  assign c_avg_i  = ({6'b0, ent.fi} >= avg_i_q);
  assign c_old    = fi_nz && c_avg_i;
  assign c_top    = fi_nz && (ent.dc < maxc_q) && c_avg_i && ({6'b0, ent.fb} >= avg_b_q);
  assign dir_cap  = {1'b0, avg_d_q} + {11'b0, ipg_q[15:4]};
  assign c_near   = fi_nz && ({7'b0, ent.dc} < dir_cap)
                    && (({7'b0, ent.fi} + {9'b0, ipg_q[15:2]}) >= {1'b0, avg_i_q})
                    && (({7'b0, ent.fb} + {9'b0, bpg_q[15:2]}) >= {1'b0, avg_b_q});
  assign c_file   = fi_nz && (ent.fb != '0);
  assign last     = ((cnt_q + NG_BITS'(1)) == n_w);

  assign lin_g        = (({1'b0, item_q.parent_group} + NG_BITS'(1)) >= n_w) ? '0 :
                        item_q.parent_group + GROUP_BITS'(1);
  assign probe_g      = wrap_add(hash_mod_q, NG_BITS'(1), n_w);
  assign adv_g        = wrap_add(g_q, NG_BITS'(1), n_w);
  assign step_n       = {step_q[NG_BITS-2:0], 1'b0};
  assign probe_next_g = wrap_add(g_q, step_n, n_w);

  always_comb begin
    logic upd;
    entry_t ne;
    state_d    = state_q;
    pass_d     = pass_q;
    item_d     = item_q;
    sum_fi_d   = sum_fi_q;
    sum_fb_d   = sum_fb_q;
    sum_d_d    = sum_d_q;
    valid_d    = valid_q;
    avg_i_d    = avg_i_q;
    avg_b_d    = avg_b_q;
    avg_d_d    = avg_d_q;
    seed_mod_d = seed_mod_q;
    pg_mod_d   = pg_mod_q;
    hash_mod_d = hash_mod_q;
    div_op_d   = div_op_q;
    div_bit_d  = div_bit_q;
    div_rem_d  = div_rem_q;
    div_dvd_d  = div_dvd_q;
    div_quo_d  = div_quo_q;
    g_d        = g_q;
    start_d    = start_q;
    best_d     = best_q;
    tgt_d      = tgt_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    found_d    = found_q;
    fail_d     = fail_q;
    best_fb_d  = best_fb_q;
    maxc_d     = maxc_q;
    done_d     = 1'b0;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_wdata  = ent;
    upd        = 1'b0;
    ne         = ent;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d = item_i;
          fail_d = 1'b0;
          tgt_d  = item_i.parent_group;
          case (item_i.mode)
            MODE_LOAD: begin
              state_d = ST_UPD_RD;
            end
            MODE_RELEASE: begin
              if ({1'b0, item_i.parent_group} >= n_w) begin
                fail_d  = 1'b1;
                state_d = ST_UPD_WR;
              end else begin
                state_d = ST_UPD_RD;
              end
            end
            default: begin
              div_op_d  = DIV_AVG_I;
              div_bit_d = '0;
              div_rem_d = '0;
              div_quo_d = '0;
              div_dvd_d = dividend(DIV_AVG_I, item_i, sum_fi_q, sum_fb_q, sum_d_q);
              state_d   = ST_DIV;
            end
          endcase
        end
      end

      ST_DIV: begin
        div_rem_d = rem_new;
        div_quo_d = quo_new;
        div_dvd_d = {div_dvd_q[DVD_BITS-2:0], 1'b0};
        div_bit_d = div_bit_q + 6'd1;
        if (div_bit_q == 6'(DVD_BITS - 1)) begin
          case (div_op_q)
            DIV_AVG_I: avg_i_d    = quo_new;
            DIV_AVG_B: avg_b_d    = quo_new;
            DIV_AVG_D: avg_d_d    = quo_new;
            DIV_SEED:  seed_mod_d = rem_new[GROUP_BITS-1:0];
            DIV_PG:    pg_mod_d   = rem_new[GROUP_BITS-1:0];
            default:   hash_mod_d = rem_new[GROUP_BITS-1:0];
          endcase
          if (div_op_q == DIV_HASH) begin
            state_d = ST_SETUP;
          end else begin
            div_op_d  = div_op_q + 3'd1;
            div_bit_d = '0;
            div_rem_d = '0;
            div_quo_d = '0;
            div_dvd_d = dividend(div_op_q + 3'd1, item_q, sum_fi_q, sum_fb_q, sum_d_q);
          end
        end
      end

      ST_SETUP: begin
        cnt_d   = '0;
        found_d = 1'b0;
        maxc_d  = ipg_q;
        state_d = ST_SCAN_RD;
        if (item_q.mode == MODE_FILE) begin
          if ({1'b0, item_q.parent_group} < n_w) begin
            pass_d = P_FPAR;
            g_d    = item_q.parent_group;
          end else if (n_w > NG_BITS'(1)) begin
            pass_d = P_FPROBE;
            step_d = NG_BITS'(1);
            g_d    = probe_g;
          end else begin
            pass_d = P_FLIN;
            g_d    = lin_g;
          end
        end else if (oldpol_q) begin
          pass_d = P_OLD;
          g_d    = '0;
        end else if (item_q.parent_is_top) begin
          pass_d  = P_TOP;
          g_d     = seed_mod_q;
          start_d = seed_mod_q;
        end else begin
          pass_d  = P_NEAR;
          g_d     = pg_mod_q;
          start_d = pg_mod_q;
        end
      end

      ST_SCAN_RD: begin
        state_d = ST_SCAN_EV;
      end

      ST_SCAN_EV: begin
        state_d = ST_SCAN_RD;
        g_d     = adv_g;
        cnt_d   = cnt_q + NG_BITS'(1);
        case (pass_q)
          P_OLD, P_TOP: begin
            if (pass_q == P_OLD) begin
              upd = c_old && (!found_q || ent.fb > best_fb_q);
            end else begin
              upd = c_top;
            end
            if (upd) begin
              best_d    = g_q;
              best_fb_d = ent.fb;
              maxc_d    = ent.dc;
              found_d   = 1'b1;
            end
            if (last) begin
              if (found_q || upd) begin
                tgt_d   = upd ? g_q : best_q;
                state_d = ST_UPD_RD;
              end else if (pass_q == P_TOP) begin
                pass_d = P_FBA;
                g_d    = start_q;
                cnt_d  = '0;
              end else begin
                fail_d  = 1'b1;
                state_d = ST_UPD_WR;
              end
            end
          end
          P_NEAR, P_FBA, P_FBB, P_FLIN: begin
            case (pass_q)
              P_NEAR:  upd = c_near;
              P_FBA:   upd = c_old;
              default: upd = fi_nz;
            endcase
            if (upd) begin
              tgt_d   = g_q;
              state_d = ST_UPD_RD;
            end else if (last) begin
              g_d   = start_q;
              cnt_d = '0;
              if (pass_q == P_NEAR) begin
                pass_d = P_FBA;
              end else if (pass_q == P_FBA && avg_i_q != '0) begin
                pass_d = P_FBB;
              end else begin
                fail_d  = 1'b1;
                state_d = ST_UPD_WR;
              end
            end
          end
          P_FPAR: begin
            cnt_d = '0;
            if (c_file) begin
              tgt_d   = g_q;
              state_d = ST_UPD_RD;
            end else if (n_w > NG_BITS'(1)) begin
              pass_d = P_FPROBE;
              step_d = NG_BITS'(1);
              g_d    = probe_g;
            end else begin
              pass_d = P_FLIN;
              g_d    = lin_g;
            end
          end
          default: begin
            cnt_d = '0;
            if (c_file) begin
              tgt_d   = g_q;
              state_d = ST_UPD_RD;
            end else if (step_n < n_w) begin
              step_d = step_n;
              g_d    = probe_next_g;
            end else begin
              pass_d = P_FLIN;
              g_d    = lin_g;
            end
          end
        endcase
      end

      ST_UPD_RD: begin
        state_d = ST_UPD_WR;
      end

      ST_UPD_WR: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        res_d.chosen_group = '0;
        res_d.status       = STATUS_OK;
        if (fail_q) begin
          res_d.status = STATUS_NOFIT;
        end else begin
          ram_we = 1'b1;
          valid_d[tgt_q] = 1'b1;
          case (item_q.mode)
            MODE_LOAD: begin
              ne.fi    = item_q.entry_free_inodes;
              ne.fb    = item_q.entry_free_blocks;
              ne.dc    = item_q.entry_dirs;
              sum_fi_d = sum_fi_q - {6'b0, ent.fi} + {6'b0, ne.fi};
              sum_fb_d = sum_fb_q - {6'b0, ent.fb} + {6'b0, ne.fb};
              sum_d_d  = sum_d_q - {6'b0, ent.dc} + {6'b0, ne.dc};
            end
            MODE_RELEASE: begin
              if (ent.fi == COUNT_MAX) begin
                res_d.status = STATUS_SAT;
              end else begin
                ne.fi    = ent.fi + 16'd1;
                sum_fi_d = sum_fi_q + 22'd1;
              end
              if (item_q.released_is_dir) begin
                if (ent.dc == '0) begin
                  res_d.status = STATUS_SAT;
                end else begin
                  ne.dc   = ent.dc - 16'd1;
                  sum_d_d = sum_d_q - 22'd1;
                end
              end
            end
            default: begin
              res_d.chosen_group = tgt_q;
              ne.fi    = ent.fi - 16'd1;
              sum_fi_d = sum_fi_q - 22'd1;
              if (item_q.mode == MODE_DIR) begin
                if (ent.dc == COUNT_MAX) begin
                  res_d.status = STATUS_SAT;
                end else begin
                  ne.dc   = ent.dc + 16'd1;
                  sum_d_d = sum_d_q + 22'd1;
                end
              end
            end
          endcase
          ram_wdata = ne;
        end
        res_d.total_free_inodes = sum_fi_d;
        res_d.total_dirs        = sum_d_d;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pass_q    <= P_OLD;
      ngrp_q    <= NG_BITS'(1);
      ipg_q     <= 16'd8192;
      bpg_q     <= 16'd32768;
      oldpol_q  <= 1'b0;
      sum_fi_q  <= '0;
      sum_fb_q  <= '0;
      sum_d_q   <= '0;
      valid_q   <= '0;
      div_op_q  <= '0;
      div_bit_q <= '0;
      cnt_q     <= '0;
      step_q    <= '0;
      found_q   <= 1'b0;
      fail_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      pass_q    <= pass_d;
      sum_fi_q  <= sum_fi_d;
      sum_fb_q  <= sum_fb_d;
      sum_d_q   <= sum_d_d;
      valid_q   <= valid_d;
      div_op_q  <= div_op_d;
      div_bit_q <= div_bit_d;
      cnt_q     <= cnt_d;
      step_q    <= step_d;
      found_q   <= found_d;
      fail_q    <= fail_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_GROUPS: ngrp_q   <= cfg_data_i[NG_BITS-1:0];
          CFG_INODES_PG:  ipg_q    <= cfg_data_i[15:0];
          CFG_BLOCKS_PG:  bpg_q    <= cfg_data_i[15:0];
          CFG_OLD_POLICY: oldpol_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    avg_i_q    <= avg_i_d;
    avg_b_q    <= avg_b_d;
    avg_d_q    <= avg_d_d;
    seed_mod_q <= seed_mod_d;
    pg_mod_q   <= pg_mod_d;
    hash_mod_q <= hash_mod_d;
    div_rem_q  <= div_rem_d;
    div_dvd_q  <= div_dvd_d;
    div_quo_q  <= div_quo_d;
    g_q        <= g_d;
    start_q    <= start_d;
    best_q     <= best_d;
    tgt_q      <= tgt_d;
    best_fb_q  <= best_fb_d;
    maxc_q     <= maxc_d;
    res_q      <= res_d;
    rd_valid_q <= valid_q[ram_addr];
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef ASSERT_OFF
  a_upd_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD_WR |=> done_o)
    else $error("update did not produce a result strobe");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN_EV |-> ({1'b0, g_q} < n_w))
    else $error("scan visited a group outside the active range");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while an item is still in work");
`endif

endmodule

/* rtl/ipl_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module ipl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/tb_inode_group_placement.sv */
`timescale 1ns / 1ps
// Self-checking bench for inode_group_placement: runs load, placement and
// release items under several register settings and checks each result.
// Depends on ipl_pkg and the inode_group_placement RTL.
module tb_inode_group_placement;
  import ipl_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam logic [CFG_BITS-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  item_t               item_i = '0;
  logic                done_o;
  result_t             result_o;
  logic                cfg_we_i = 1'b0;
  logic [CFG_BITS-1:0] cfg_idx_i = '0;
  logic [31:0]         cfg_data_i = '0;

  inode_group_placement dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .done_o(done_o), .result_o(result_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // placement table mirror
  longint unsigned grp_free_ino [MAX_GROUPS];
  longint unsigned grp_free_blk [MAX_GROUPS];
  longint unsigned grp_dirs     [MAX_GROUPS];
  longint unsigned tot_free_ino, tot_free_blk, tot_dirs;
  longint unsigned reg_groups, reg_ipg, reg_bpg, reg_total_blks, reg_old_policy;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      sent_cnt = 0;
  int      accepted_cnt = 0;
  int      result_cnt = 0;
  int      errors = 0;
  int      gap_left = 0;
  int      idle_cycles = 0;
  int      mode_cnt [4];
  int      status_cnt [3];
  bit      quiet = 1'b0;

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch on result %0d: %s got %0h want %0h", result_cnt, field, got, want);
    errors++;
  endtask

  function automatic int fallback_group(longint unsigned n, longint unsigned from,
                                        longint unsigned avg);
    longint unsigned g;
    int found;
    found = -1;
    for (longint unsigned i = 0; i < n && found < 0; i++) begin
      g = (from + i) % n;
      if (grp_free_ino[g] != 0 && grp_free_ino[g] >= avg) found = int'(g);
    end
    if (found < 0 && avg != 0)
      for (longint unsigned i = 0; i < n && found < 0; i++) begin
        g = (from + i) % n;
        if (grp_free_ino[g] != 0) found = int'(g);
      end
    return found;
  endfunction

  function automatic result_t place_and_count(item_t it);
    result_t         r;
    longint unsigned n, pg, h, step, avg_i, avg_b, max_cnt, dir_cap, g;
    longint          min_i, min_b;
    int              pick;
    r = '0;
    n = (reg_groups == 0) ? 1 : ((reg_groups > MAX_GROUPS) ? MAX_GROUPS : reg_groups);
    pg = it.parent_group;
    pick = -1;
    avg_i = tot_free_ino / n;
    avg_b = tot_free_blk / n;
    case (it.mode)
      MODE_LOAD: begin
        tot_free_ino = tot_free_ino - grp_free_ino[pg] + it.entry_free_inodes;
        tot_free_blk = tot_free_blk - grp_free_blk[pg] + it.entry_free_blocks;
        tot_dirs     = tot_dirs - grp_dirs[pg] + it.entry_dirs;
        grp_free_ino[pg] = it.entry_free_inodes;
        grp_free_blk[pg] = it.entry_free_blocks;
        grp_dirs[pg]     = it.entry_dirs;
      end
      MODE_DIR, MODE_FILE: begin
        if (it.mode == MODE_FILE) begin
          if (pg < n && grp_free_ino[pg] != 0 && grp_free_blk[pg] != 0) pick = int'(pg);
          else begin
            h = (pg + it.parent_inode) % n;
            for (step = 1; step < n && pick < 0; step = step << 1) begin
              h = h + step;
              if (h >= n) h = h % n;
              if (grp_free_ino[h] != 0 && grp_free_blk[h] != 0) pick = int'(h);
            end
            h = pg;
            for (longint unsigned i = 0; i < n && pick < 0; i++) begin
              h++;
              if (h >= n) h = 0;
              if (grp_free_ino[h] != 0) pick = int'(h);
            end
          end
        end else if (reg_old_policy != 0) begin
          for (g = 0; g < n; g++)
            if (grp_free_ino[g] != 0 && grp_free_ino[g] >= avg_i)
              if (pick < 0 || grp_free_blk[g] > grp_free_blk[pick]) pick = int'(g);
        end else if (it.parent_is_top) begin
          h = it.start_seed % n;
          max_cnt = reg_ipg;
          for (longint unsigned i = 0; i < n; i++) begin
            g = (h + i) % n;
            if (grp_free_ino[g] != 0 && grp_dirs[g] < max_cnt && grp_free_ino[g] >= avg_i
                && grp_free_blk[g] >= avg_b) begin
              pick = int'(g);
              max_cnt = grp_dirs[g];
            end
          end
          if (pick < 0) pick = fallback_group(n, h, avg_i);
        end else begin
          dir_cap = tot_dirs / n + reg_ipg / 16;
          min_i = longint'(avg_i) - longint'(reg_ipg / 4);
          min_b = longint'(avg_b) - longint'(reg_bpg / 4);
          for (longint unsigned i = 0; i < n && pick < 0; i++) begin
            g = (pg + i) % n;
            if (grp_free_ino[g] != 0 && grp_dirs[g] < dir_cap
                && longint'(grp_free_ino[g]) >= min_i && longint'(grp_free_blk[g]) >= min_b)
              pick = int'(g);
          end
          if (pick < 0) pick = fallback_group(n, pg, avg_i);
        end
        if (pick < 0) r.status = STATUS_NOFIT;
        else begin
          r.chosen_group = pick[GROUP_BITS-1:0];
          grp_free_ino[pick]--;
          tot_free_ino--;
          if (it.mode == MODE_DIR) begin
            if (grp_dirs[pick] >= COUNT_MAX) r.status = STATUS_SAT;
            else begin
              grp_dirs[pick]++;
              tot_dirs++;
            end
          end
        end
      end
      default: begin
        if (pg >= n) r.status = STATUS_NOFIT;
        else begin
          if (grp_free_ino[pg] >= COUNT_MAX) r.status = STATUS_SAT;
          else begin
            grp_free_ino[pg]++;
            tot_free_ino++;
          end
          if (it.released_is_dir) begin
            if (grp_dirs[pg] == 0) r.status = STATUS_SAT;
            else begin
              grp_dirs[pg]--;
              tot_dirs--;
            end
          end
        end
      end
    endcase
    r.total_free_inodes = tot_free_ino[SUM_BITS-1:0];
    r.total_dirs = tot_dirs[SUM_BITS-1:0];
    return r;
  endfunction

  function automatic item_t rand_item(int n);
    item_t it;
    int    pick;
    it.mode = MODE_LOAD;
    pick = $urandom_range(99);
    if (pick >= 20) it.mode = MODE_DIR;
    if (pick >= 50) it.mode = MODE_FILE;
    if (pick >= 80) it.mode = MODE_RELEASE;
    it.parent_group = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(n - 1));
    it.parent_inode = $urandom;
    it.parent_is_top = 1'($urandom_range(1));
    it.start_seed = $urandom;
    it.entry_free_inodes = 16'($urandom);
    it.entry_free_blocks = 16'($urandom);
    it.entry_dirs = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    case ($urandom_range(7))
      0: it.entry_free_inodes = '0;
      1: it.entry_free_inodes = '1;
      2: it.entry_dirs = '1;
      3: it.entry_free_blocks = '0;
      default: ;
    endcase
    it.released_is_dir = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic item_t make_item(logic [1:0] mode, logic [5:0] grp,
                                      logic [15:0] fi, logic [15:0] fb, logic [15:0] dc,
                                      logic flag);
    item_t it;
    it = '0;
    it.mode = mode;
    it.parent_group = grp;
    it.entry_free_inodes = fi;
    it.entry_free_blocks = fb;
    it.entry_dirs = dc;
    it.parent_is_top = flag;
    it.released_is_dir = flag;
    it.parent_inode = '1;
    it.start_seed = '1;
    return it;
  endfunction

  always @(negedge clk_i) begin
    if (!start || accepted_cnt == sent_cnt) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_items.size() > 0 && rst_ni) begin
        item_i <= pending_items.pop_front();
        start <= 1'b1;
        sent_cnt++;
        if (!quiet && $urandom_range(3) == 0) gap_left <= $urandom_range(3, 1);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (start && !busy && rst_ni) begin
      expected_results.push_back(place_and_count(item_i));
      mode_cnt[item_i.mode]++;
      accepted_cnt++;
    end
    if (done_o) begin
      if (expected_results.size() == 0) begin
        $display("result %0d arrived with nothing expected", result_cnt);
        errors++;
      end else begin
        result_t want;
        want = expected_results.pop_front();
        if (want.status < 3) status_cnt[want.status]++;
        if (result_o.chosen_group !== want.chosen_group)
          report_mismatch("chosen_group", result_o.chosen_group, want.chosen_group);
        if (result_o.status !== want.status)
          report_mismatch("status", result_o.status, want.status);
        if (result_o.total_free_inodes !== want.total_free_inodes)
          report_mismatch("total_free_inodes", result_o.total_free_inodes,
                          want.total_free_inodes);
        if (result_o.total_dirs !== want.total_dirs)
          report_mismatch("total_dirs", result_o.total_dirs, want.total_dirs);
      end
      result_cnt++;
    end
    if ((start && !busy) || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_BITS-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_NUM_GROUPS: reg_groups = data[6:0];
      CFG_INODES_PG:  reg_ipg = data[15:0];
      CFG_BLOCKS_PG:  reg_bpg = data[15:0];
      CFG_TOTAL_BLKS: reg_total_blks = data;
      CFG_OLD_POLICY: reg_old_policy = data[0];
      default: ;
    endcase
  endtask

  task automatic setup_phase(logic [31:0] groups, logic [31:0] ipg, logic [31:0] bpg,
                             logic [31:0] total, logic [31:0] policy);
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    write_reg(CFG_NUM_GROUPS, groups);
    write_reg(CFG_INODES_PG, ipg);
    write_reg(CFG_BLOCKS_PG, bpg);
    write_reg(CFG_TOTAL_BLKS, total);
    write_reg(CFG_OLD_POLICY, policy);
    write_reg(CFG_UNUSED_IDX, $urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic fill_phase(int count);
    int n;
    item_t it;
    n = (reg_groups == 0) ? 1 : ((reg_groups > MAX_GROUPS) ? MAX_GROUPS : int'(reg_groups));
    for (int g = 0; g < n; g++) begin
      it = make_item(MODE_LOAD, g[5:0], 16'($urandom_range(200, 1)),
                     16'($urandom_range(400)), 16'($urandom_range(12)), 1'b0);
      pending_items.push_back(it);
    end
    for (int i = 0; i < count; i++) pending_items.push_back(rand_item(n));
  endtask

  initial begin
    for (int g = 0; g < MAX_GROUPS; g++) begin
      grp_free_ino[g] = 0;
      grp_free_blk[g] = 0;
      grp_dirs[g] = 0;
    end
    tot_free_ino = 0;
    tot_free_blk = 0;
    tot_dirs = 0;
    reg_groups = 1;
    reg_ipg = 8192;
    reg_bpg = 32768;
    reg_total_blks = 0;
    reg_old_policy = 0;
    for (int i = 0; i < 4; i++) mode_cnt[i] = 0;
    for (int i = 0; i < 3; i++) status_cnt[i] = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults after reset: one group
    pending_items.push_back(make_item(MODE_DIR, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1));
    pending_items.push_back(make_item(MODE_DIR, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(MODE_FILE, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(MODE_RELEASE, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1));
    pending_items.push_back(make_item(MODE_RELEASE, 6'd5, 16'd0, 16'd0, 16'd0, 1'b1));
    pending_items.push_back(make_item(MODE_LOAD, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    pending_items.push_back(make_item(MODE_RELEASE, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(MODE_DIR, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1));
    pending_items.push_back(make_item(MODE_DIR, 6'd63, 16'd0, 16'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(MODE_FILE, 6'd63, 16'd0, 16'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(MODE_RELEASE, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1));
    pending_items.push_back(make_item(MODE_LOAD, 6'd63, 16'h1234, 16'h0, 16'h9, 1'b0));
    pending_items.push_back(make_item(MODE_LOAD, 6'd0, 16'h1, 16'h0, 16'h0, 1'b0));
    pending_items.push_back(make_item(MODE_FILE, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(MODE_FILE, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(MODE_RELEASE, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1));
    pending_items.push_back(make_item(MODE_LOAD, 6'd0, 16'h0, 16'h0, 16'h0, 1'b0));
    pending_items.push_back(make_item(MODE_LOAD, 6'd63, 16'h0, 16'h0, 16'h0, 1'b0));

    setup_phase(8, 8192, 32768, 32'h1234_5678, 0);
    fill_phase(60);
    setup_phase(8, 8192, 32768, 32'h0, 1);
    fill_phase(60);
    setup_phase(64, 65535, 65535, 32'hFFFF_FFFF, 0);
    fill_phase(40);
    setup_phase(0, 1, 1, 32'h0, 1);
    fill_phase(40);
    setup_phase(0, 1, 1, 32'h0, 0);
    fill_phase(40);
    setup_phase(127, 16, 4, $urandom, 0);
    fill_phase(40);
    setup_phase(3, 100, 200, $urandom, 0);
    fill_phase(60);
    setup_phase(17, $urandom_range(65535, 1), $urandom_range(65535, 1), $urandom, 1);
    fill_phase(40);
    setup_phase(5, 40, 65535, $urandom, 0);
    quiet = 1'b1;
    fill_phase(80);

    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d items: %0d loads, %0d dir, %0d file, %0d release placements",
             accepted_cnt, mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3]);
    $display("statuses seen: %0d ok, %0d no fit, %0d saturated; %0d mismatches",
             status_cnt[0], status_cnt[1], status_cnt[2], errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
